// ----- design/dhcp_option_scanner_assert.svh -----
// assertion helpers, clocked on clk_i and disabled while rst_ni is low
`ifndef DHCP_OPTION_SCANNER_ASSERT_SVH
`define DHCP_OPTION_SCANNER_ASSERT_SVH

// property holds in the same cycle as its trigger
`define DOS_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// property holds in the cycle after its trigger
`define DOS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/dos_pkg.sv -----
package dos_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } item_t;

  typedef struct packed {
    logic [2:0]  outcome;
    logic [7:0]  message_type;
    logic        type_seen;
    logic [31:0] req_addr;
    logic        ip_found;
    logic [31:0] server_id;
    logic        server_seen;
  } result_t;

  // scan phases
  localparam logic [2:0] PH_CODE    = 3'd0;
  localparam logic [2:0] PH_LEN     = 3'd1;
  localparam logic [2:0] PH_SKIP    = 3'd2;
  localparam logic [2:0] PH_TYPEVAL = 3'd3;
  localparam logic [2:0] PH_CAPTURE = 3'd4;
  localparam logic [2:0] PH_DONE    = 3'd5;

  localparam logic [7:0] OPT_PAD      = 8'd0;
  localparam logic [7:0] OPT_REQ_IP   = 8'd50;
  localparam logic [7:0] OPT_MSG_TYPE = 8'd53;
  localparam logic [7:0] OPT_SERVER   = 8'd54;
  localparam logic [7:0] OPT_END      = 8'd255;

  localparam logic [7:0] ADDR_LEN = 8'd4;
  localparam logic [7:0] TYPE_LEN = 8'd1;

  localparam logic [2:0] OUT_BAD_COOKIE = 3'd0;
  localparam logic [2:0] OUT_OFFER      = 3'd1;
  localparam logic [2:0] OUT_ACK        = 3'd2;
  localparam logic [2:0] OUT_REQ_NO_IP  = 3'd3;
  localparam logic [2:0] OUT_OTHER      = 3'd4;
  localparam logic [2:0] OUT_UNKNOWN    = 3'd5;
  localparam logic [2:0] OUT_NO_TYPE    = 3'd6;
  localparam logic [2:0] OUT_TRUNCATED  = 3'd7;

  localparam logic [7:0] MT_DISCOVER = 8'd1;
  localparam logic [7:0] MT_OFFER    = 8'd2;
  localparam logic [7:0] MT_REQUEST  = 8'd3;
  localparam logic [7:0] MT_INFORM   = 8'd8;

  localparam logic [2:0] COOKIE_LEN = 3'd4;

  typedef struct packed {
    logic        done;
    logic        type_seen;
    logic [7:0]  type_val;
    logic        server_seen;
    logic [31:0] server_val;
  } type_status_t;

  typedef struct packed {
    logic        done;
    logic        ip_found;
    logic [31:0] ip_val;
  } ip_status_t;

  typedef struct packed {
    logic       step;   // byte goes to the scans
    logic       clear;  // packet ends with this byte
    logic [7:0] data;
  } scan_ctl_t;

  function automatic logic [7:0] cookie_byte(input logic [1:0] idx);
    logic [7:0] b;
    unique case (idx)
      2'd0:    b = 8'h63;
      2'd1:    b = 8'h82;
      2'd2:    b = 8'h53;
      default: b = 8'h63;
    endcase
    return b;
  endfunction

endpackage

// ----- design/dos_type_scan.sv -----
module dos_type_scan
  import dos_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  scan_ctl_t    ctl_i,
  output type_status_t status_o
);

  logic [2:0]  phase_q, phase_d;
  logic [7:0]  code_q, code_d;
  logic [7:0]  rem_q, rem_d;
  logic        tseen_q, tseen_d;
  logic [7:0]  tval_q, tval_d;
  logic        sseen_q, sseen_d;
  logic [31:0] shift_q, shift_d;

  always_comb begin
    phase_d = phase_q;
    code_d  = code_q;
    rem_d   = rem_q;
    tseen_d = tseen_q;
    tval_d  = tval_q;
    sseen_d = sseen_q;
    shift_d = shift_q;
    if (ctl_i.step) begin
      unique case (phase_q)
        PH_CODE: begin
          if (ctl_i.data == OPT_END) begin
            phase_d = PH_DONE;
          end else begin
            code_d  = ctl_i.data;
            phase_d = PH_LEN;
          end
        end
        PH_LEN: begin
          priority if (code_q == OPT_MSG_TYPE && ctl_i.data == TYPE_LEN) begin
            phase_d = PH_TYPEVAL;
          end else if (code_q == OPT_SERVER && ctl_i.data == ADDR_LEN) begin
            rem_d   = ADDR_LEN;
            phase_d = PH_CAPTURE;
          end else if (ctl_i.data == 8'd0) begin
            phase_d = PH_CODE;
          end else begin
            rem_d   = ctl_i.data;
            phase_d = PH_SKIP;
          end
        end
        PH_SKIP: begin
          rem_d = rem_q - 8'd1;
          if (rem_q == 8'd1) phase_d = PH_CODE;
        end
        PH_TYPEVAL: begin
          // only the first option 53 counts
          if (!tseen_q) begin
            tseen_d = 1'b1;
            tval_d  = ctl_i.data;
          end
          phase_d = PH_CODE;
        end
        PH_CAPTURE: begin
          shift_d = {shift_q[23:0], ctl_i.data};
          rem_d   = rem_q - 8'd1;
          if (rem_q == 8'd1) begin
            sseen_d = 1'b1;
            phase_d = PH_DONE;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_CODE;
      code_q  <= '0;
      rem_q   <= '0;
      tseen_q <= 1'b0;
      sseen_q <= 1'b0;
    end else if (ctl_i.clear) begin
      phase_q <= PH_CODE;
      code_q  <= '0;
      rem_q   <= '0;
      tseen_q <= 1'b0;
      sseen_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      code_q  <= code_d;
      rem_q   <= rem_d;
      tseen_q <= tseen_d;
      sseen_q <= sseen_d;
    end
  end

  // values are qualified by the seen flags
  always_ff @(posedge clk_i) begin
    tval_q  <= tval_d;
    shift_q <= shift_d;
  end

  assign status_o.done        = (phase_d == PH_DONE);
  assign status_o.type_seen   = tseen_d;
  assign status_o.type_val    = tval_d;
  assign status_o.server_seen = sseen_d;
  assign status_o.server_val  = shift_d;

endmodule

// ----- design/dos_ip_scan.sv -----
module dos_ip_scan
  import dos_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  scan_ctl_t  ctl_i,
  output ip_status_t status_o
);

  logic [2:0]  phase_q, phase_d;
  logic [7:0]  code_q, code_d;
  logic [7:0]  rem_q, rem_d;
  logic        found_q, found_d;
  logic [31:0] shift_q, shift_d;

  always_comb begin
    phase_d = phase_q;
    code_d  = code_q;
    rem_d   = rem_q;
    found_d = found_q;
    shift_d = shift_q;
    if (ctl_i.step) begin
      unique case (phase_q)
        PH_CODE: begin
          if (ctl_i.data == OPT_END) begin
            phase_d = PH_DONE;
          end else if (ctl_i.data != OPT_PAD) begin
            code_d  = ctl_i.data;
            phase_d = PH_LEN;
          end
        end
        PH_LEN: begin
          priority if (code_q == OPT_REQ_IP && ctl_i.data == ADDR_LEN) begin
            rem_d   = ADDR_LEN;
            phase_d = PH_CAPTURE;
          end else if (ctl_i.data == 8'd0) begin
            phase_d = PH_CODE;
          end else begin
            rem_d   = ctl_i.data;
            phase_d = PH_SKIP;
          end
        end
        PH_SKIP: begin
          rem_d = rem_q - 8'd1;
          if (rem_q == 8'd1) phase_d = PH_CODE;
        end
        PH_CAPTURE: begin
          shift_d = {shift_q[23:0], ctl_i.data};
          rem_d   = rem_q - 8'd1;
          if (rem_q == 8'd1) begin
            found_d = 1'b1;
            phase_d = PH_DONE;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_CODE;
      code_q  <= '0;
      rem_q   <= '0;
      found_q <= 1'b0;
    end else if (ctl_i.clear) begin
      phase_q <= PH_CODE;
      code_q  <= '0;
      rem_q   <= '0;
      found_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      code_q  <= code_d;
      rem_q   <= rem_d;
      found_q <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    shift_q <= shift_d;
  end

  assign status_o.done     = (phase_d == PH_DONE);
  assign status_o.ip_found = found_d;
  assign status_o.ip_val   = shift_d;

endmodule

// ----- design/dhcp_option_scanner.sv -----
// channel | valid      | stall       | payload
// in      | in_valid_i | in_stall_o  | in_item_i    (item_t: data_byte, last_byte)
// out     | out_valid_o| out_stall_i | out_result_o (result_t, one beat per packet)
//
// one byte per cycle sustained while in_stall_o is low; each byte is held in the input register
// and a last byte's verdict passes from there into the result register
// the scans update from the input register in one pass, so bytes follow back to back
// a last byte waits in the input register only while the result register holds
// a beat under stall; other bytes never wait
// reset clears the cookie check, both scans and both valid flags
`include "dhcp_option_scanner_assert.svh"

module dhcp_option_scanner
  import dos_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  input  item_t   in_item_i,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  output result_t out_result_o
);

  logic         in_valid_q;
  item_t        in_q;
  logic         out_valid_q;
  result_t      out_q, out_d;
  logic [2:0]   cookie_idx_q, cookie_idx_d;
  logic         cookie_bad_q, cookie_bad_d;
  logic         out_free, consume, emit, scan_en;
  scan_ctl_t    scan_ctl;
  type_status_t type_st;
  ip_status_t   ip_st;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign consume    = in_valid_q && (!in_q.last_byte || out_free);
  assign emit       = consume && in_q.last_byte;
  assign in_stall_o = in_valid_q && !consume;

  assign scan_en = !cookie_bad_q && (cookie_idx_q == COOKIE_LEN);

  always_comb begin
    cookie_idx_d = cookie_idx_q;
    cookie_bad_d = cookie_bad_q;
    if (!cookie_bad_q && cookie_idx_q != COOKIE_LEN) begin
      cookie_bad_d = (in_q.data_byte != cookie_byte(cookie_idx_q[1:0]));
      cookie_idx_d = cookie_idx_q + 3'd1;
    end
  end

  assign scan_ctl.step  = consume && scan_en;
  assign scan_ctl.clear = emit;
  assign scan_ctl.data  = in_q.data_byte;

  dos_type_scan u_type_scan (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (scan_ctl),
    .status_o (type_st)
  );

  dos_ip_scan u_ip_scan (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (scan_ctl),
    .status_o (ip_st)
  );

  // verdict on the state left after the last byte
  always_comb begin
    priority if (cookie_bad_d) begin
      out_d.outcome = OUT_BAD_COOKIE;
    end else if (cookie_idx_d != COOKIE_LEN || !type_st.done) begin
      out_d.outcome = OUT_TRUNCATED;
    end else if (!type_st.type_seen) begin
      out_d.outcome = OUT_NO_TYPE;
    end else if (type_st.type_val == MT_DISCOVER) begin
      out_d.outcome = OUT_OFFER;
    end else if (type_st.type_val == MT_REQUEST) begin
      if (ip_st.ip_found)   out_d.outcome = OUT_ACK;
      else if (!ip_st.done) out_d.outcome = OUT_TRUNCATED;
      else                  out_d.outcome = OUT_REQ_NO_IP;
    end else if (type_st.type_val >= MT_OFFER && type_st.type_val <= MT_INFORM) begin
      out_d.outcome = OUT_OTHER;
    end else begin
      out_d.outcome = OUT_UNKNOWN;
    end
    out_d.type_seen    = type_st.type_seen && !cookie_bad_d;
    out_d.message_type = out_d.type_seen ? type_st.type_val : 8'd0;
    out_d.ip_found     = ip_st.ip_found && !cookie_bad_d;
    out_d.req_addr     = out_d.ip_found ? ip_st.ip_val : 32'd0;
    out_d.server_seen  = type_st.server_seen && !cookie_bad_d;
    out_d.server_id    = out_d.server_seen ? type_st.server_val : 32'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      cookie_idx_q <= '0;
      cookie_bad_q <= 1'b0;
    end else begin
      if (!in_stall_o) in_valid_q <= in_valid_i;
      if (emit) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
      if (emit) begin
        cookie_idx_q <= '0;
        cookie_bad_q <= 1'b0;
      end else if (consume) begin
        cookie_idx_q <= cookie_idx_d;
        cookie_bad_q <= cookie_bad_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) in_q <= in_item_i;
    if (emit) out_q <= out_d;
  end

  assign out_valid_o  = out_valid_q;
  assign out_result_o = out_q;

  `DOS_ASSERT(a_cookie_idx_range, 1'b1, cookie_idx_q <= COOKIE_LEN, "cookie index past cookie")
  `DOS_ASSERT(a_stall_needs_item, in_stall_o, in_valid_q && in_q.last_byte,
              "stall without pending last byte")
  `DOS_ASSERT_NEXT(a_packet_restart, emit, cookie_idx_q == 3'd0 && !cookie_bad_q,
                   "cookie check not restarted")
  `DOS_ASSERT(a_bad_cookie_clean, out_valid_q && out_q.outcome == OUT_BAD_COOKIE,
              !out_q.type_seen && !out_q.ip_found && !out_q.server_seen,
              "bad cookie verdict carries captures")
  `DOS_ASSERT(a_ack_has_ip, out_valid_q && out_q.outcome == OUT_ACK,
              out_q.ip_found && out_q.type_seen && out_q.message_type == MT_REQUEST,
              "ack without requested address")

endmodule

// ----- tb/dhcp_option_scanner_tb.sv -----
`timescale 1ns / 100ps

module dhcp_option_scanner_tb
  import dos_pkg::*;
();

  localparam logic [31:0] MAGIC_WORD = 32'h63825363;

  logic    clk_i = 1'b0;
  logic    rst_ni = 1'b0;
  logic    in_valid_i = 1'b0;
  logic    in_stall_o;
  item_t   in_item_i = '0;
  logic    out_valid_o;
  logic    out_stall_i = 1'b0;
  result_t out_result_o;

  dhcp_option_scanner uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_item_i    (in_item_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_result_o (out_result_o)
  );

  always #5 clk_i = ~clk_i;

  // parser mirror
  logic [2:0]  hdr_pos;
  logic        hdr_bad;
  logic [2:0]  ts_phase;
  logic [7:0]  ts_code;
  logic [7:0]  ts_left;
  logic [2:0]  ip_phase;
  logic [7:0]  ip_code;
  logic [7:0]  ip_left;
  logic        typ_seen;
  logic [7:0]  typ_val;
  logic        req_ok;
  logic [31:0] req_ip;
  logic [31:0] req_acc;
  logic        srv_ok;
  logic [31:0] srv_ip;
  logic [31:0] srv_acc;

  result_t    verdict_q[$];
  logic [7:0] pkt_bytes[$];

  int send_idle_pct = 0;
  int stall_pct = 0;
  int errors = 0;
  int packets_sent = 0;
  int bytes_sent = 0;
  int verdict_hits[8];

  function void clear_parser();
    hdr_pos  = '0;
    hdr_bad  = 1'b0;
    ts_phase = PH_CODE;
    ts_code  = '0;
    ts_left  = '0;
    ip_phase = PH_CODE;
    ip_code  = '0;
    ip_left  = '0;
    typ_seen = 1'b0;
    typ_val  = '0;
    req_ok   = 1'b0;
    req_ip   = '0;
    req_acc  = '0;
    srv_ok   = 1'b0;
    srv_ip   = '0;
    srv_acc  = '0;
  endfunction

  // type scan: no pad handling, stops at end code or a full server id
  function void type_scan(input logic [7:0] b);
    case (ts_phase)
      PH_CODE: begin
        if (b == OPT_END) begin
          ts_phase = PH_DONE;
        end else begin
          ts_code  = b;
          ts_phase = PH_LEN;
        end
      end
      PH_LEN: begin
        if (ts_code == OPT_MSG_TYPE && b == TYPE_LEN) begin
          ts_phase = PH_TYPEVAL;
        end else if (ts_code == OPT_SERVER && b == ADDR_LEN) begin
          ts_left  = ADDR_LEN;
          srv_acc  = '0;
          ts_phase = PH_CAPTURE;
        end else if (b == 8'd0) begin
          ts_phase = PH_CODE;
        end else begin
          ts_left  = b;
          ts_phase = PH_SKIP;
        end
      end
      PH_SKIP: begin
        ts_left = ts_left - 8'd1;
        if (ts_left == 8'd0) ts_phase = PH_CODE;
      end
      PH_TYPEVAL: begin
        if (!typ_seen) begin
          typ_seen = 1'b1;
          typ_val  = b;
        end
        ts_phase = PH_CODE;
      end
      PH_CAPTURE: begin
        srv_acc = {srv_acc[23:0], b};
        ts_left = ts_left - 8'd1;
        if (ts_left == 8'd0) begin
          srv_ok   = 1'b1;
          srv_ip   = srv_acc;
          ts_phase = PH_DONE;
        end
      end
      default: ;
    endcase
  endfunction

  // ip scan: skips pads, takes the first complete option 50
  function void ip_scan(input logic [7:0] b);
    case (ip_phase)
      PH_CODE: begin
        if (b == OPT_END) begin
          ip_phase = PH_DONE;
        end else if (b != OPT_PAD) begin
          ip_code  = b;
          ip_phase = PH_LEN;
        end
      end
      PH_LEN: begin
        if (ip_code == OPT_REQ_IP && b == ADDR_LEN) begin
          ip_left  = ADDR_LEN;
          req_acc  = '0;
          ip_phase = PH_CAPTURE;
        end else if (b == 8'd0) begin
          ip_phase = PH_CODE;
        end else begin
          ip_left  = b;
          ip_phase = PH_SKIP;
        end
      end
      PH_SKIP: begin
        ip_left = ip_left - 8'd1;
        if (ip_left == 8'd0) ip_phase = PH_CODE;
      end
      PH_CAPTURE: begin
        req_acc = {req_acc[23:0], b};
        ip_left = ip_left - 8'd1;
        if (ip_left == 8'd0) begin
          req_ok   = 1'b1;
          req_ip   = req_acc;
          ip_phase = PH_DONE;
        end
      end
      default: ;
    endcase
  endfunction

  function void track_byte(input item_t beat);
    logic [7:0] b;
    result_t v;
    b = beat.data_byte;
    if (!hdr_bad) begin
      if (hdr_pos < COOKIE_LEN) begin
        if (b != MAGIC_WORD[31 - 8 * hdr_pos -: 8]) hdr_bad = 1'b1;
        hdr_pos = hdr_pos + 3'd1;
      end else begin
        type_scan(b);
        ip_scan(b);
      end
    end
    if (beat.last_byte) begin
      v = '0;
      if (hdr_bad)
        v.outcome = OUT_BAD_COOKIE;
      else if (hdr_pos < COOKIE_LEN || ts_phase != PH_DONE)
        v.outcome = OUT_TRUNCATED;
      else if (!typ_seen)
        v.outcome = OUT_NO_TYPE;
      else if (typ_val == MT_DISCOVER)
        v.outcome = OUT_OFFER;
      else if (typ_val == MT_REQUEST)
        v.outcome = req_ok ? OUT_ACK :
                    (ip_phase != PH_DONE ? OUT_TRUNCATED : OUT_REQ_NO_IP);
      else if (typ_val >= MT_OFFER && typ_val <= MT_INFORM)
        v.outcome = OUT_OTHER;
      else
        v.outcome = OUT_UNKNOWN;
      if (!hdr_bad) begin
        v.type_seen    = typ_seen;
        v.message_type = typ_seen ? typ_val : 8'd0;
        v.ip_found     = req_ok;
        v.req_addr     = req_ok ? req_ip : 32'd0;
        v.server_seen  = srv_ok;
        v.server_id    = srv_ok ? srv_ip : 32'd0;
      end
      verdict_q.push_back(v);
      clear_parser();
    end
  endfunction

  initial clear_parser();

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) track_byte(in_item_i);
  end

  function void check_field(input string what, input logic [31:0] want,
                            input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, what, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk_i) begin : verdict_check
    result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (verdict_q.size() == 0) begin
        $display("%0t: unexpected verdict beat, expected none actual %h",
                 $time, out_result_o);
        errors++;
      end else begin
        want = verdict_q.pop_front();
        verdict_hits[want.outcome]++;
        check_field("outcome", 32'(want.outcome), 32'(out_result_o.outcome));
        check_field("message_type", 32'(want.message_type),
                    32'(out_result_o.message_type));
        check_field("type_seen", 32'(want.type_seen), 32'(out_result_o.type_seen));
        check_field("req_addr", want.req_addr, out_result_o.req_addr);
        check_field("ip_found", 32'(want.ip_found), 32'(out_result_o.ip_found));
        check_field("server_id", want.server_id, out_result_o.server_id);
        check_field("server_seen", 32'(want.server_seen),
                    32'(out_result_o.server_seen));
      end
    end
  end

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  task automatic send_byte(input logic [7:0] b, input logic is_last);
    item_t beat;
    beat.data_byte = b;
    beat.last_byte = is_last;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= beat;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    bytes_sent++;
  endtask

  task automatic send_packet();
    for (int i = 0; i < pkt_bytes.size(); i++)
      send_byte(pkt_bytes[i], i == pkt_bytes.size() - 1);
    pkt_bytes.delete();
    packets_sent++;
  endtask

  task automatic push_option(input logic [7:0] code, input int len);
    pkt_bytes.push_back(code);
    pkt_bytes.push_back(8'(len));
    repeat (len) pkt_bytes.push_back(8'($urandom_range(255)));
  endtask

  // mostly well-formed option lists, some noise, bad cookies and cut packets
  task automatic build_random_packet();
    int len;
    int cut;
    int bad_pos;
    logic [7:0] code;
    pkt_bytes.delete();
    if ($urandom_range(99) < 5) begin
      repeat ($urandom_range(12, 1)) pkt_bytes.push_back(8'($urandom_range(255)));
      return;
    end
    for (int k = 0; k < 4; k++) pkt_bytes.push_back(MAGIC_WORD[31 - 8 * k -: 8]);
    if ($urandom_range(99) < 8) begin
      bad_pos = $urandom_range(3);
      pkt_bytes[bad_pos] = pkt_bytes[bad_pos] ^ 8'($urandom_range(255, 1));
    end
    if ($urandom_range(99) < 60) begin
      pkt_bytes.push_back(OPT_MSG_TYPE);
      pkt_bytes.push_back(TYPE_LEN);
      pkt_bytes.push_back($urandom_range(1) ? MT_REQUEST : MT_DISCOVER);
    end
    repeat ($urandom_range(6)) begin
      case ($urandom_range(9))
        0: pkt_bytes.push_back(OPT_PAD);
        1, 2: begin
          pkt_bytes.push_back(OPT_MSG_TYPE);
          pkt_bytes.push_back(TYPE_LEN);
          pkt_bytes.push_back($urandom_range(3) == 0 ? 8'($urandom_range(255))
                                                     : 8'($urandom_range(9)));
        end
        3: begin
          len = $urandom_range(3);
          if (len == 1) len = 2;
          push_option(OPT_MSG_TYPE, len);
        end
        4, 5: push_option(OPT_REQ_IP, int'(ADDR_LEN));
        6: push_option(OPT_SERVER, int'(ADDR_LEN));
        7: begin
          code = $urandom_range(1) ? OPT_REQ_IP : OPT_SERVER;
          len = $urandom_range(6);
          if (len == 4) len = 5;
          push_option(code, len);
        end
        8: push_option(8'($urandom_range(255)), $urandom_range(6));
        default: push_option(8'($urandom_range(255)), $urandom_range(40, 7));
      endcase
    end
    if ($urandom_range(99) < 85) pkt_bytes.push_back(OPT_END);
    repeat ($urandom_range(2)) pkt_bytes.push_back(8'($urandom_range(255)));
    if ($urandom_range(99) < 12) begin
      cut = $urandom_range(pkt_bytes.size(), 1);
      while (pkt_bytes.size() > cut) void'(pkt_bytes.pop_back());
    end
  endtask

  task automatic test_cookie_check();
    // wrong first byte that is also the last
    pkt_bytes = '{OPT_PAD};
    send_packet();
    // packet ends inside a good cookie
    pkt_bytes = '{8'h63, 8'h82};
    send_packet();
    // wrong final cookie byte
    pkt_bytes = '{8'h63, 8'h82, 8'h53, 8'h64, OPT_END};
    send_packet();
  endtask

  task automatic test_basic_verdicts();
    pkt_bytes = '{8'h63, 8'h82, 8'h53, 8'h63,
                  OPT_MSG_TYPE, TYPE_LEN, MT_DISCOVER, OPT_END};
    send_packet();
    pkt_bytes = '{8'h63, 8'h82, 8'h53, 8'h63,
                  OPT_MSG_TYPE, TYPE_LEN, MT_REQUEST,
                  OPT_REQ_IP, ADDR_LEN, 8'hc0, 8'ha8, 8'h7f, 8'hff,
                  OPT_SERVER, ADDR_LEN, 8'h0a, 8'h00, 8'h80, 8'h01, OPT_END};
    send_packet();
  endtask

  task automatic test_random_packets(input int idle_pct, input int hold_pct,
                                     input int byte_budget);
    int start_bytes;
    send_idle_pct = idle_pct;
    stall_pct     = hold_pct;
    start_bytes   = bytes_sent;
    while (bytes_sent - start_bytes < byte_budget) begin
      build_random_packet();
      send_packet();
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_cookie_check();
    test_basic_verdicts();
    test_random_packets(0, 0, 250);
    test_random_packets(69, 0, 250);
    test_random_packets(0, 69, 250);
    test_random_packets(22, 22, 250);
    in_valid_i <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    $display("covered %0d packets in %0d bytes under four sender/receiver idle mixes",
             packets_sent, bytes_sent);
    $display("verdicts: bad %0d offer %0d ack %0d req_no_ip %0d other %0d unknown %0d",
             verdict_hits[OUT_BAD_COOKIE], verdict_hits[OUT_OFFER],
             verdict_hits[OUT_ACK], verdict_hits[OUT_REQ_NO_IP],
             verdict_hits[OUT_OTHER], verdict_hits[OUT_UNKNOWN]);
    $display("          no_type %0d truncated %0d, mismatches %0d",
             verdict_hits[OUT_NO_TYPE], verdict_hits[OUT_TRUNCATED], errors);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d verdicts outstanding", verdict_q.size());
    $display("simulation failed");
    $finish;
  end

endmodule
